[rtl/core/src_pkg.sv]
// Package: shared types and constants for sensor reading compensation.
package src_pkg;

    localparam int CmdW  = 2;
    localparam int RawW  = 20;
    localparam int ValW  = 32;
    localparam int AddrW = 6;

    localparam logic [CmdW-1:0] KIND_TEMP  = 2'd0;
    localparam logic [CmdW-1:0] KIND_PRESS = 2'd1;
    localparam logic [CmdW-1:0] KIND_HUM   = 2'd2;

    localparam logic [2:0] REG_TEMP   = 3'd0;
    localparam logic [2:0] REG_PLOW   = 3'd1;
    localparam logic [2:0] REG_PHIGH  = 3'd2;
    localparam logic [2:0] REG_PNINE  = 3'd3;
    localparam logic [2:0] REG_HUM    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

endpackage

[rtl/core/sensor_reading_compensation.sv]
// Top level: sensor reading compensation with a shared multiplier and divider.
// Result timing follows the steps of the shared 32x32 multiplier and, for pressure
// with a nonzero divisor, the bit-serial divider; an unused kind goes straight to
// output. A new request is taken only in idle, after the last result is accepted.
// Reset (synchronous, active low) clears control, coefficients and fine temperature.
module sensor_reading_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [src_pkg::AddrW-1:0] i_paddr,
    input  logic [63:0] i_pwdata,
    output logic [63:0] o_prdata,
    output logic        o_pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // raw_reading [19:0], zero pad
    input  logic [1:0]  s_axis_tuser,  // cmd [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // value [31:0]
    output logic [2:0]  m_axis_tuser   // kind [1:0], div_zero [2]
);

    src_pkg::t_state r_state, n_state;
    logic [47:0] r_tc;
    logic [63:0] r_pl, r_ph, r_hc;
    logic [15:0] r_p9;
    logic [31:0] r_fine;
    logic [1:0]  r_kind;
    logic [19:0] r_adc;
    logic [4:0]  r_step;
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_val;
    logic        r_dz;
    logic [31:0] r_quo, r_rem, r_dvd;
    logic [5:0]  r_dcnt;

    logic [31:0] m_x, m_y, m_p;
    logic [31:0] sh_out;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6, adc32;
    logic        wr;
    logic [32:0] rem_sh;

    assign wr = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign adc32 = {12'd0, r_adc};

    assign t1 = {16'd0, r_tc[15:0]};
    assign t2 = {{16{r_tc[31]}}, r_tc[31:16]};
    assign t3 = {{16{r_tc[47]}}, r_tc[47:32]};
    assign p1 = {16'd0, r_pl[15:0]};
    assign p2 = {{16{r_pl[31]}}, r_pl[31:16]};
    assign p3 = {{16{r_pl[47]}}, r_pl[47:32]};
    assign p4 = {{16{r_pl[63]}}, r_pl[63:48]};
    assign p5 = {{16{r_ph[15]}}, r_ph[15:0]};
    assign p6 = {{16{r_ph[31]}}, r_ph[31:16]};
    assign p7 = {{16{r_ph[47]}}, r_ph[47:32]};
    assign p8 = {{16{r_ph[63]}}, r_ph[63:48]};
    assign p9 = {{16{r_p9[15]}}, r_p9};
    assign h1 = {24'd0, r_hc[7:0]};
    assign h2 = {{16{r_hc[23]}}, r_hc[23:8]};
    assign h3 = {24'd0, r_hc[31:24]};
    assign h4 = {{20{r_hc[43]}}, r_hc[43:32]};
    assign h5 = {{20{r_hc[55]}}, r_hc[55:44]};
    assign h6 = {{24{r_hc[63]}}, r_hc[63:56]};

    // shared multiplier, low 32 bits
    assign m_p = m_x * m_y;

    // operand selection per step
    always_comb begin
        m_x = 32'd0;
        m_y = 32'd0;
        case (r_kind)
            src_pkg::KIND_TEMP: begin
                case (r_step)
                    5'd0: begin m_x = $signed(adc32) >>> 3; m_y = 32'd1; end
                    5'd1: begin m_x = r_a - (t1 << 1); m_y = t2; end
                    5'd2: begin m_x = r_b; m_y = r_b; end
                    5'd3: begin m_x = $signed(r_c) >>> 12; m_y = t3; end
                    5'd4: begin m_x = r_a + r_d; m_y = 32'd5; end
                    default: ;
                endcase
            end
            src_pkg::KIND_PRESS: begin
                case (r_step)
                    5'd1: begin m_x = $signed(r_a) >>> 2; m_y = $signed(r_a) >>> 2; end
                    5'd2: begin m_x = $signed(r_b) >>> 11; m_y = p6; end
                    5'd3: begin m_x = r_a; m_y = p5; end
                    5'd4: begin m_x = p3; m_y = $signed(r_b) >>> 13; end
                    5'd5: begin m_x = p2; m_y = r_a; end
                    5'd7: begin m_x = 32'd32768 + r_d; m_y = p1; end
                    5'd9: begin m_x = r_e; m_y = 32'd3125; end
                    5'd10: begin m_x = r_val >> 3; m_y = r_val >> 3; end
                    5'd11: begin m_x = p9; m_y = r_a >> 13; end
                    5'd12: begin m_x = r_val >> 2; m_y = p8; end
                    default: ;
                endcase
            end
            default: begin
                case (r_step)
                    5'd1: begin m_x = h5; m_y = r_a; end
                    5'd2: begin m_x = r_a; m_y = h6; end
                    5'd3: begin m_x = r_a; m_y = h3; end
                    5'd4: begin m_x = r_c; m_y = r_d; end
                    5'd5: begin m_x = r_c; m_y = h2; end
                    5'd6: begin m_x = r_b; m_y = r_c; end
                    5'd7: begin m_x = $signed(r_d) >>> 15; m_y = $signed(r_d) >>> 15; end
                    5'd8: begin m_x = $signed(r_e) >>> 7; m_y = h1; end
                    default: ;
                endcase
            end
        endcase
    end

    assign sh_out = $signed(m_p) >>> 4;
    assign rem_sh = {r_rem, r_dvd[31]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            src_pkg::ST_IDLE: if (s_axis_tvalid) n_state = src_pkg::ST_RUN;
            src_pkg::ST_RUN: begin
                if (r_kind == src_pkg::KIND_PRESS && r_step == 5'd9 && r_dz == 1'b0)
                    n_state = src_pkg::ST_DIV;
                else if ((r_kind == src_pkg::KIND_TEMP && r_step == 5'd4) ||
                         (r_kind == src_pkg::KIND_PRESS && r_step == 5'd13) ||
                         (r_kind == src_pkg::KIND_PRESS && r_dz) ||
                         (r_kind == src_pkg::KIND_HUM && r_step == 5'd9) ||
                         (r_kind == 2'd3))
                    n_state = src_pkg::ST_OUT;
            end
            src_pkg::ST_DIV: if (r_dcnt == 6'd32) n_state = src_pkg::ST_RUN;
            src_pkg::ST_OUT: if (m_axis_tready) n_state = src_pkg::ST_IDLE;
            default: n_state = src_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= src_pkg::ST_IDLE;
            r_tc <= '0; r_pl <= '0; r_ph <= '0; r_p9 <= '0; r_hc <= '0;
            r_fine <= '0;
            r_step <= '0;
            r_dz <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr) begin
                case (i_paddr[5:3])
                    src_pkg::REG_TEMP:  r_tc <= i_pwdata[47:0];
                    src_pkg::REG_PLOW:  r_pl <= i_pwdata;
                    src_pkg::REG_PHIGH: r_ph <= i_pwdata;
                    src_pkg::REG_PNINE: r_p9 <= i_pwdata[15:0];
                    src_pkg::REG_HUM:   r_hc <= i_pwdata;
                    default: ;
                endcase
            end
            unique case (r_state)
                src_pkg::ST_IDLE: begin
                    r_kind <= s_axis_tuser;
                    r_adc <= s_axis_tdata[19:0];
                    r_step <= '0;
                    r_dz <= 1'b0;
                    r_val <= '0;
                end
                src_pkg::ST_RUN: begin
                    r_step <= r_step + 5'd1;
                    case (r_kind)
                        src_pkg::KIND_TEMP: begin
                            case (r_step)
                                5'd0: begin r_a <= m_p; r_b <= ($signed(adc32) >>> 4) - t1; end
                                5'd1: r_a <= $signed(m_p) >>> 11;
                                5'd2: r_c <= m_p;
                                5'd3: r_d <= $signed(m_p) >>> 14;
                                5'd4: begin
                                    r_fine <= r_a + r_d;
                                    r_val <= $signed(m_p + 32'd128) >>> 8;
                                end
                                default: ;
                            endcase
                        end
                        src_pkg::KIND_PRESS: begin
                            case (r_step)
                                5'd0: r_a <= $unsigned($signed(r_fine) >>> 1) - 32'd64000;
                                5'd1: r_b <= m_p;
                                5'd2: r_c <= m_p;
                                5'd3: r_c <= $unsigned($signed(r_c + (m_p << 1)) >>> 2)
                                             + (p4 << 16);
                                5'd4: r_d <= $signed(m_p) >>> 3;
                                5'd5: r_d <= $signed(r_d + $unsigned($signed(m_p) >>> 1))
                                             >>> 18;
                                5'd6: ;
                                5'd7: begin
                                    r_d <= $signed(m_p) >>> 15;
                                    r_dz <= (($signed(m_p) >>> 15) == 32'd0);
                                end
                                5'd8: r_e <= (32'd1048576 - adc32)
                                             - $unsigned($signed(r_c) >>> 12);
                                5'd9: begin
                                    r_e <= m_p;
                                    r_dvd <= m_p[31] ? m_p : (m_p << 1);
                                    r_rem <= '0;
                                    r_quo <= '0;
                                    r_dcnt <= '0;
                                end
                                5'd10: r_a <= m_p;
                                5'd11: r_a <= $signed(m_p) >>> 12;
                                5'd12: r_b <= $signed(m_p) >>> 13;
                                5'd13: r_val <= r_val
                                                + $unsigned($signed(r_a + r_b + p7) >>> 4);
                                default: ;
                            endcase
                        end
                        src_pkg::KIND_HUM: begin
                            case (r_step)
                                5'd0: r_a <= r_fine - 32'd76800;
                                5'd1: r_b <= $signed((adc32 << 14) - (h4 << 20) - m_p
                                                     + 32'd16384) >>> 15;
                                5'd2: r_c <= $signed(m_p) >>> 10;
                                5'd3: r_d <= $unsigned($signed(m_p) >>> 11) + 32'd32768;
                                5'd4: r_c <= $unsigned($signed(m_p) >>> 10) + 32'd2097152;
                                5'd5: r_c <= $signed(m_p + 32'd8192) >>> 14;
                                5'd6: r_d <= m_p;
                                5'd7: r_e <= m_p;
                                5'd8: r_e <= r_d - sh_out;
                                5'd9: begin
                                    if (r_e[31]) r_val <= '0;
                                    else if (r_e > 32'd419430400) r_val <= 32'd102400;
                                    else r_val <= r_e >> 12;
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                src_pkg::ST_DIV: begin
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt != 6'd32) begin
                        r_dvd <= r_dvd << 1;
                        if (rem_sh >= {1'b0, r_d}) begin
                            r_rem <= 32'(rem_sh - {1'b0, r_d});
                            r_quo <= {r_quo[30:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[31:0];
                            r_quo <= {r_quo[30:0], 1'b0};
                        end
                    end else begin
                        r_val <= r_e[31] ? (r_quo << 1) : r_quo;
                    end
                end
                src_pkg::ST_OUT: ;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        case (i_paddr[5:3])
            src_pkg::REG_TEMP:  o_prdata = {16'd0, r_tc};
            src_pkg::REG_PLOW:  o_prdata = r_pl;
            src_pkg::REG_PHIGH: o_prdata = r_ph;
            src_pkg::REG_PNINE: o_prdata = {48'd0, r_p9};
            src_pkg::REG_HUM:   o_prdata = r_hc;
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == src_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_state == src_pkg::ST_OUT);
    assign m_axis_tdata  = r_val;
    assign m_axis_tuser  = {r_dz, r_kind};

`ifndef NO_ASSERTIONS
    a_dz_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == src_pkg::KIND_PRESS
            && m_axis_tdata == 32'd0)
        else $error("div_zero on bad result");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready while result pending");
    a_hum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == src_pkg::KIND_HUM
            |-> m_axis_tdata <= 32'd102400)
        else $error("humidity out of range");
`endif

endmodule
